>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; each macro expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nie_pkg.sv
// Shared types and constants of the sparse-input network evaluator.
// Used by nie_mac, the top level and the checker.
package nie_pkg;

   localparam int IDX_W  = 10;   // result tag index, covers up to 1024 neurons
   localparam int J_W    = 5;    // output column counter of the dense layers
   localparam int ACT_W  = 13;   // clipped activation, 0 .. 4096
   localparam int SUM_W  = 32;
   localparam int FRAC_W = 12;
   localparam int TERM_W = 34;
   localparam int PROD_W = 46;
   localparam logic [1:0] DRAIN_LAST = 2'd3;
   localparam logic [ACT_W-1:0] ONE_Q12 = 13'd4096;

   typedef enum logic [2:0] {
      FN_LOAD_W = 3'd0,
      FN_LOAD_B = 3'd1,
      FN_RESET  = 3'd2,
      FN_ADD    = 3'd3,
      FN_SUB    = 3'd4,
      FN_EVAL   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      LAYER_FIRST  = 2'd0,
      LAYER_SECOND = 2'd1,
      LAYER_THIRD  = 2'd2,
      LAYER_FOURTH = 2'd3
   } layer_type;

   typedef enum logic [1:0] {
      K_ADD   = 2'd0,
      K_SUB   = 2'd1,
      K_DENSE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      DST_NONE  = 3'd0,
      DST_ACC   = 3'd1,
      DST_ACTB  = 3'd2,
      DST_ACTC  = 3'd3,
      DST_SCORE = 3'd4
   } dest_type;

   typedef struct packed {
      dest_type         dest;
      logic [IDX_W-1:0] idx;
   } tag_type;

   typedef struct packed {
      kind_type                kind;
      logic                    use_run;
      logic signed [SUM_W-1:0] w;
      logic [ACT_W-1:0]        act;
      logic signed [SUM_W-1:0] base;
      tag_type                 tag;
   } mac_cmd_type;

   typedef struct packed {
      logic    valid;
      logic    sat;
      tag_type tag;
   } mac_status_type;

   // Clamp a Q.12 sum to [0.0, 1.0]
   function automatic logic [ACT_W-1:0] clip_relu(input logic signed [SUM_W-1:0] x);
      logic [ACT_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > $signed({19'b0, ONE_Q12})) begin
         r = ONE_Q12;
      end else begin
         r = x[ACT_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/nie_mac.sv
// Shared two-stage multiply/saturating-accumulate unit of the evaluator.
// Depends on nie_pkg for the command, tag and status types.
module nie_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  nie_pkg::mac_cmd_type        cmd,
   output nie_pkg::mac_status_type     stat,
   output logic signed [31:0]          sum
);
   import nie_pkg::*;

   localparam logic signed [TERM_W:0] SAT_HI = 35'sd2147483647;
   localparam logic signed [TERM_W:0] SAT_LO = -35'sd2147483648;

   logic signed [PROD_W-1:0] prod;
   logic signed [TERM_W-1:0] term;
   logic                     v1_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [SUM_W-1:0]  base_ff;
   logic                     use_run_ff;
   tag_type                  tag1_ff;
   logic signed [TERM_W:0]   addend;
   logic signed [TERM_W:0]   wide_sum;
   logic signed [SUM_W-1:0]  run_in;
   logic                     sat_in;
   logic signed [SUM_W-1:0]  run_ff;
   logic                     ov_ff;
   logic                     osat_ff;
   tag_type                  otag_ff;

   // Stage 1: term select; dense term is floor(w * act / 4096)
   always_comb begin
      prod = cmd.w * $signed({1'b0, cmd.act});
      case (cmd.kind)
         K_ADD:   term = TERM_W'(cmd.w);
         K_SUB:   term = -TERM_W'(cmd.w);
         K_DENSE: term = prod[PROD_W-1:FRAC_W];
         default: term = '0;
      endcase
   end

   // Stage 2: add to running sum or base, saturate to 32 bits
   always_comb begin
      addend   = use_run_ff ? (TERM_W+1)'(run_ff) : (TERM_W+1)'(base_ff);
      wide_sum = addend + (TERM_W+1)'(term_ff);
      sat_in   = 1'b0;
      if (wide_sum > SAT_HI) begin
         run_in = SAT_HI[SUM_W-1:0];
         sat_in = 1'b1;
      end else if (wide_sum < SAT_LO) begin
         run_in = SAT_LO[SUM_W-1:0];
         sat_in = 1'b1;
      end else begin
         run_in = wide_sum[SUM_W-1:0];
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         v1_ff <= cmd_valid;
         ov_ff <= v1_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      term_ff    <= term;
      base_ff    <= cmd.base;
      use_run_ff <= cmd.use_run;
      tag1_ff    <= cmd.tag;
      otag_ff    <= tag1_ff;
      osat_ff    <= sat_in;
      if (v1_ff) begin
         run_ff <= run_in;
      end
   end

   assign stat.valid = ov_ff;
   assign stat.sat   = osat_ff;
   assign stat.tag   = otag_ff;
   assign sum        = run_ff;

endmodule

>>> rtl/nnue_incremental_evaluator.sv
// Sparse-input network evaluator: weight memories, accumulator and sequencer.
// Depends on nie_pkg and nie_mac.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    func, layer_sel, row/col index, coef, feature
//   rsp      out        rsp_valid/stall    score, saturated (evaluate only)
//
// Loads complete on acceptance. Accumulator reset, add and remove step through all HIDDEN_A
// accumulator entries. Evaluate runs the three dense layers, one multiply-accumulate
// per cycle through the single shared MAC with a drain between layers, then waits for rsp.
// After reset a clearing pass zeroes the accumulator; req_stall stays high meanwhile
// and whenever an item is in progress.
module nnue_incremental_evaluator #(
   parameter int NUM_FEATURES = 768,
   parameter int HIDDEN_A     = 1024,
   parameter int HIDDEN_B     = 8,
   parameter int HIDDEN_C     = 32,
   parameter int COEF_WIDTH   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [1:0]         req_layer_sel,
   input  logic [9:0]         req_row_index,
   input  logic [9:0]         req_col_index,
   input  logic signed [15:0] req_coef_value,
   input  logic [9:0]         req_feature,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_score,
   output logic               rsp_saturated
);
   import nie_pkg::*;

   localparam int AW_A  = $clog2(HIDDEN_A);
   localparam int AW_F  = $clog2(NUM_FEATURES * HIDDEN_A);
   localparam int AW_W2 = $clog2(HIDDEN_A * HIDDEN_B);
   localparam int AW_W3 = (HIDDEN_B * HIDDEN_C > 1) ? $clog2(HIDDEN_B * HIDDEN_C) : 1;
   localparam int AW_B  = (HIDDEN_B > 1) ? $clog2(HIDDEN_B) : 1;
   localparam int AW_C  = (HIDDEN_C > 1) ? $clog2(HIDDEN_C) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BIAS, S_UPD, S_L2, S_L3, S_L4, S_DRAIN, S_OUT
   } state_type;

   function automatic logic signed [31:0] sext_coef(input logic [COEF_WIDTH-1:0] v);
      return 32'($signed(v));
   endfunction

   // Memories
   logic [COEF_WIDTH-1:0] w1_mem   [NUM_FEATURES * HIDDEN_A];
   logic [COEF_WIDTH-1:0] b1_mem   [HIDDEN_A];
   logic signed [31:0]    acc_mem  [HIDDEN_A];
   logic [COEF_WIDTH-1:0] w2_mem   [HIDDEN_A * HIDDEN_B];
   logic [COEF_WIDTH-1:0] b2_mem   [HIDDEN_B];
   logic [COEF_WIDTH-1:0] w3_mem   [HIDDEN_B * HIDDEN_C];
   logic [COEF_WIDTH-1:0] b3_mem   [HIDDEN_C];
   logic [COEF_WIDTH-1:0] w4_mem   [HIDDEN_C];
   logic [ACT_W-1:0]      actb_mem [HIDDEN_B];
   logic [ACT_W-1:0]      actc_mem [HIDDEN_C];
   logic [COEF_WIDTH-1:0] b4_ff;

   logic [COEF_WIDTH-1:0] w1_rd, b1_rd, w2_rd, b2_rd, w3_rd, b3_rd, w4_rd;
   logic signed [31:0]    acc_rd;
   logic [ACT_W-1:0]      actb_rd, actc_rd;

   // Control
   state_type          state_ff, resume_ff, p1_state_ff;
   logic [AW_A-1:0]    i_ff;
   logic [J_W-1:0]     j_ff;
   logic [AW_W2-1:0]   waddr_ff;
   logic [AW_F-1:0]    fbase_ff;
   logic               sub_ff;
   logic [1:0]         drain_ff;
   logic               sat_ff;
   logic               p1_valid_ff, p1_first_ff;
   tag_type            p1_tag_ff;
   logic               rsp_valid_ff, rsp_sat_ff;
   logic signed [31:0] rsp_score_ff;

   logic               accept, issue, i_last, j_last;
   logic [AW_W2-1:0]   stride;
   tag_type            tag_c;
   logic [COEF_WIDTH-1:0] coef_c;
   logic [31:0]        w1_wa, w2_wa, w3_wa;
   logic [AW_F-1:0]    w1_ra;
   logic               row_ok_f, row_ok_a, row_ok_b, row_ok_c;
   logic               col_ok_a, col_ok_b, col_ok_c, col_zero;
   mac_cmd_type        cmd;
   mac_status_type     mst;
   logic signed [31:0] mac_sum;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = rsp_score_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Load decode
   always_comb begin
      coef_c   = COEF_WIDTH'({16'b0, req_coef_value});
      w1_wa    = 32'(req_row_index) * 32'(HIDDEN_A) + 32'(req_col_index);
      w2_wa    = 32'(req_row_index) * 32'(HIDDEN_B) + 32'(req_col_index);
      w3_wa    = 32'(req_row_index) * 32'(HIDDEN_C) + 32'(req_col_index);
      row_ok_f = 32'(req_row_index) < 32'(NUM_FEATURES);
      row_ok_a = 32'(req_row_index) < 32'(HIDDEN_A);
      row_ok_b = 32'(req_row_index) < 32'(HIDDEN_B);
      row_ok_c = 32'(req_row_index) < 32'(HIDDEN_C);
      col_ok_a = 32'(req_col_index) < 32'(HIDDEN_A);
      col_ok_b = 32'(req_col_index) < 32'(HIDDEN_B);
      col_ok_c = 32'(req_col_index) < 32'(HIDDEN_C);
      col_zero = (req_col_index == '0);
      w1_ra    = fbase_ff + AW_F'(i_ff);
   end

   // Sequencer decode: loop ends, weight stride, result tag
   always_comb begin
      issue  = 1'b0;
      i_last = (i_ff == AW_A'(HIDDEN_A - 1));
      j_last = 1'b0;
      stride = '0;
      tag_c  = '{dest: DST_NONE, idx: '0};
      case (state_ff)
         S_BIAS, S_UPD: begin
            issue = 1'b1;
            tag_c = '{dest: DST_ACC, idx: IDX_W'(i_ff)};
         end
         S_L2: begin
            issue  = 1'b1;
            j_last = (j_ff == J_W'(HIDDEN_B - 1));
            stride = AW_W2'(HIDDEN_B);
            if (i_last) tag_c = '{dest: DST_ACTB, idx: IDX_W'(j_ff)};
         end
         S_L3: begin
            issue  = 1'b1;
            i_last = (i_ff == AW_A'(HIDDEN_B - 1));
            j_last = (j_ff == J_W'(HIDDEN_C - 1));
            stride = AW_W2'(HIDDEN_C);
            if (i_last) tag_c = '{dest: DST_ACTC, idx: IDX_W'(j_ff)};
         end
         S_L4: begin
            issue  = 1'b1;
            i_last = (i_ff == AW_A'(HIDDEN_C - 1));
            if (i_last) tag_c = '{dest: DST_SCORE, idx: '0};
         end
         default: ;
      endcase
   end

   // State machine, counters and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         resume_ff    <= S_IDLE;
         p1_state_ff  <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         waddr_ff     <= '0;
         drain_ff     <= '0;
         sub_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= issue;
         p1_state_ff <= state_ff;

         // Result transfer may complete while the pipeline still drains
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Sticky saturation; the score transfer reports and clears it
         if (mst.valid) begin
            sat_ff <= sat_ff | mst.sat;
            if (mst.tag.dest == DST_SCORE) begin
               rsp_valid_ff <= 1'b1;
               rsp_score_ff <= mac_sum;
               rsp_sat_ff   <= sat_ff | mst.sat;
               sat_ff       <= 1'b0;
            end
         end

         case (state_ff)
            S_CLEAR: begin
               i_ff <= i_ff + 1'b1;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  case (req_func)
                     FN_RESET: state_ff <= S_BIAS;
                     FN_ADD, FN_SUB: begin
                        if (32'(req_feature) < 32'(NUM_FEATURES)) begin
                           state_ff <= S_UPD;
                           sub_ff   <= (req_func == FN_SUB);
                           fbase_ff <= AW_F'(32'(req_feature) * 32'(HIDDEN_A));
                        end
                     end
                     FN_EVAL: state_ff <= S_L2;
                     default: ;
                  endcase
               end
            end
            S_BIAS, S_UPD, S_L4: begin
               i_ff <= i_ff + 1'b1;
               if (i_last) begin
                  state_ff  <= S_DRAIN;
                  resume_ff <= (state_ff == S_L4) ? S_OUT : S_IDLE;
                  drain_ff  <= DRAIN_LAST;
                  i_ff      <= '0;
               end
            end
            S_L2, S_L3: begin
               i_ff     <= i_ff + 1'b1;
               waddr_ff <= waddr_ff + stride;
               if (i_last) begin
                  i_ff <= '0;
                  if (j_last) begin
                     state_ff  <= S_DRAIN;
                     resume_ff <= (state_ff == S_L2) ? S_L3 : S_L4;
                     drain_ff  <= DRAIN_LAST;
                     j_ff      <= '0;
                     waddr_ff  <= '0;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     waddr_ff <= AW_W2'(j_ff) + 1'b1;
                  end
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff - 1'b1;
               if (drain_ff == '0) state_ff <= resume_ff;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Issue-stage payload
   always_ff @(posedge clock) begin
      p1_first_ff <= (i_ff == '0);
      p1_tag_ff   <= tag_c;
   end

   // First-layer weights and biases
   always_ff @(posedge clock) begin
      if (accept && req_func == FN_LOAD_W && req_layer_sel == LAYER_FIRST
          && row_ok_f && col_ok_a) begin
         w1_mem[w1_wa[AW_F-1:0]] <= coef_c;
      end
      if (accept && req_func == FN_LOAD_B && req_layer_sel == LAYER_FIRST && col_ok_a) begin
         b1_mem[req_col_index[AW_A-1:0]] <= coef_c;
      end
      w1_rd <= w1_mem[w1_ra];
      b1_rd <= b1_mem[i_ff];
   end

   // Accumulator: clearing pass or MAC write-back
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         acc_mem[i_ff] <= '0;
      end else if (mst.valid && mst.tag.dest == DST_ACC) begin
         acc_mem[mst.tag.idx[AW_A-1:0]] <= mac_sum;
      end
      acc_rd <= acc_mem[i_ff];
   end

   // Dense-layer coefficients
   always_ff @(posedge clock) begin
      if (accept && req_func == FN_LOAD_W) begin
         case (req_layer_sel)
            LAYER_SECOND: if (row_ok_a && col_ok_b) w2_mem[w2_wa[AW_W2-1:0]] <= coef_c;
            LAYER_THIRD:  if (row_ok_b && col_ok_c) w3_mem[w3_wa[AW_W3-1:0]] <= coef_c;
            LAYER_FOURTH: if (row_ok_c && col_zero) w4_mem[req_row_index[AW_C-1:0]] <= coef_c;
            default: ;
         endcase
      end
      if (accept && req_func == FN_LOAD_B) begin
         case (req_layer_sel)
            LAYER_SECOND: if (col_ok_b) b2_mem[req_col_index[AW_B-1:0]] <= coef_c;
            LAYER_THIRD:  if (col_ok_c) b3_mem[req_col_index[AW_C-1:0]] <= coef_c;
            LAYER_FOURTH: if (col_zero) b4_ff <= coef_c;
            default: ;
         endcase
      end
      w2_rd <= w2_mem[waddr_ff];
      w3_rd <= w3_mem[waddr_ff[AW_W3-1:0]];
      w4_rd <= w4_mem[i_ff[AW_C-1:0]];
      b2_rd <= b2_mem[j_ff[AW_B-1:0]];
      b3_rd <= b3_mem[j_ff[AW_C-1:0]];
   end

   // Hidden activations of layers two and three
   always_ff @(posedge clock) begin
      if (mst.valid && mst.tag.dest == DST_ACTB) begin
         actb_mem[mst.tag.idx[AW_B-1:0]] <= clip_relu(mac_sum);
      end
      if (mst.valid && mst.tag.dest == DST_ACTC) begin
         actc_mem[mst.tag.idx[AW_C-1:0]] <= clip_relu(mac_sum);
      end
      actb_rd <= actb_mem[i_ff[AW_B-1:0]];
      actc_rd <= actc_mem[i_ff[AW_C-1:0]];
   end

   // Operand select for the shared MAC
   always_comb begin
      cmd = '{kind: K_ADD, use_run: 1'b0, w: '0, act: '0, base: '0, tag: p1_tag_ff};
      case (p1_state_ff)
         S_BIAS: begin
            cmd.w = sext_coef(b1_rd);
         end
         S_UPD: begin
            cmd.kind = sub_ff ? K_SUB : K_ADD;
            cmd.w    = sext_coef(w1_rd);
            cmd.base = acc_rd;
         end
         S_L2: begin
            cmd.kind    = K_DENSE;
            cmd.use_run = !p1_first_ff;
            cmd.w       = sext_coef(w2_rd);
            cmd.act     = clip_relu(acc_rd);
            cmd.base    = sext_coef(b2_rd);
         end
         S_L3: begin
            cmd.kind    = K_DENSE;
            cmd.use_run = !p1_first_ff;
            cmd.w       = sext_coef(w3_rd);
            cmd.act     = actb_rd;
            cmd.base    = sext_coef(b3_rd);
         end
         S_L4: begin
            cmd.kind    = K_DENSE;
            cmd.use_run = !p1_first_ff;
            cmd.w       = sext_coef(w4_rd);
            cmd.act     = actc_rd;
            cmd.base    = sext_coef(b4_ff);
         end
         default: ;
      endcase
   end

   nie_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (p1_valid_ff),
      .cmd       (cmd),
      .stat      (mst),
      .sum       (mac_sum)
   );

endmodule

>>> rtl/nie_checker.sv
// Port-level checks of the evaluator, bound to the top level.
// Depends on nie_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nie_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_score
);
   import nie_pkg::*;

   // A stalled result holds
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_score), "rsp dropped or changed under stall")

   // No input transfer while a result waits
   `CHK_SAME(a_busy_with_rsp, rsp_valid, req_stall, "input taken while result pending")

   // Clearing pass follows reset
   `CHK_SAME(a_clear_after_reset, $past(reset), req_stall, "input open right after reset")

   // Evaluate keeps the block busy
   `CHK_NEXT(a_eval_busy, req_valid && !req_stall && req_func == FN_EVAL, req_stall && !rsp_valid, "evaluate finished too early")

endmodule

bind nnue_incremental_evaluator nie_checker u_nie_checker (.*);
